[design/xmr_pkg.sv]
// Shared types and constants for the XMODEM receiver.
// No dependencies; the receiver, core and result register import this package.
`timescale 1ns / 1ps
`default_nettype none

package xmr_pkg;

   // Link control characters
   localparam logic [7:0] CH_SOH = 8'h01;
   localparam logic [7:0] CH_STX = 8'h02;
   localparam logic [7:0] CH_EOT = 8'h04;
   localparam logic [7:0] CH_ACK = 8'h06;
   localparam logic [7:0] CH_NAK = 8'h15;
   localparam logic [7:0] CH_CAN = 8'h18;
   localparam logic [7:0] CH_REQ = 8'h43;

   // Request kinds
   localparam logic [1:0] KIND_BYTE  = 2'd0;
   localparam logic [1:0] KIND_TICK  = 2'd1;
   localparam logic [1:0] KIND_START = 2'd2;

   // Register indexes
   localparam logic [1:0] REG_USE_CRC16     = 2'd0;
   localparam logic [1:0] REG_RETRY_LIMIT   = 2'd1;
   localparam logic [1:0] REG_TIMEOUT_LIMIT = 2'd2;
   localparam logic [1:0] REG_BUF_CAPACITY  = 2'd3;

   // Termination status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_CANCELLED = 3'd1;
   localparam logic [2:0] ST_BAD_HDR   = 3'd2;
   localparam logic [2:0] ST_NO_SYNC   = 3'd3;
   localparam logic [2:0] ST_RETRIES   = 3'd4;
   localparam logic [2:0] ST_OVERFLOW  = 3'd5;

   localparam int SMALL_BLOCK = 128;
   localparam int LARGE_BLOCK = 1024;
   localparam int INDEX_W     = 11;
   localparam int CAP_W       = 24;
   localparam int TOTAL_W     = 24;

   localparam logic [15:0] CRC_POLY = 16'h1021;

   // One result without the framing fields
   typedef struct packed {
      logic       send_valid;
      logic [7:0] send_byte;
      logic       data_valid;
      logic [7:0] data_byte;
      logic       commit;
      logic       drop;
      logic       done_res;
      logic [2:0] status;
   } result_type;

   // All results of one request: count 3 means an abort (head, CAN, CAN with status)
   typedef struct packed {
      logic [1:0]         count;
      logic [2:0]         end_status;
      result_type         head;
      logic [TOTAL_W-1:0] total;
   } bundle_type;

endpackage

`default_nettype wire

[design/xmr_req_if.sv]
// Request channel of the XMODEM receiver: valid/ready plus one event.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface xmr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] rx_byte;

   modport source (output valid, output kind, output rx_byte, input ready);
   modport sink (input valid, input kind, input rx_byte, output ready);
endinterface

`default_nettype wire

[design/xmr_rsp_if.sv]
// Response channel of the XMODEM receiver: valid/ready plus one result.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface xmr_rsp_if;
   logic        valid;
   logic        ready;
   logic        send_valid;
   logic [7:0]  send_byte;
   logic        data_valid;
   logic [7:0]  data_byte;
   logic        commit;
   logic        drop;
   logic        done_res;
   logic [2:0]  status;
   logic [23:0] received_total;
   logic        last;

   modport source (output valid, output send_valid, output send_byte, output data_valid,
                   output data_byte, output commit, output drop, output done_res,
                   output status, output received_total, output last, input ready);
   modport sink (input valid, input send_valid, input send_byte, input data_valid,
                 input data_byte, input commit, input drop, input done_res,
                 input status, input received_total, input last, output ready);
endinterface

`default_nettype wire

[design/xmodem_receiver.sv]
// Top level of the XMODEM receiver: input register, protocol core, result register.
// Depends on xmr_pkg, xmr_req_if, xmr_rsp_if, xmr_core and xmr_serial.
//
//   port     | direction | carries
//   ---------+-----------+-------------------------------------------------
//   req_ch   | in        | kind, rx_byte (link byte, timeout tick, start)
//   rsp_ch   | out       | control byte, payload byte, commit/drop, status
//   csr_*    | in        | write-only registers: use_crc16 .. buffer_capacity
//
// A request is taken into the input register; once the result register is free, the core
// updates its state and loads all results of the request into the result register, from
// which the first result is offered. Results leave one per cycle while rsp_ch.ready is
// high; a request yields no result or one, or three when it aborts with CANs.
// Reset is synchronous and returns the registers to their defaults and the
// protocol to idle. A stalled response holds the result register; the input
// register takes one more request and then holds req_ch.ready low.
`timescale 1ns / 1ps
`default_nettype none

module xmodem_receiver
   import xmr_pkg::*;
#(
   parameter int COUNT_WIDTH = 24
) (
   input  wire logic             clock,
   input  wire logic             reset,
   xmr_req_if.sink               req_ch,
   xmr_rsp_if.source             rsp_ch,
   input  wire logic             csr_we,
   input  wire logic [1:0]       csr_index,
   input  wire logic [CAP_W-1:0] csr_wdata
);

   logic       in_valid_ff;
   logic [1:0] in_kind_ff;
   logic [7:0] in_byte_ff;
   logic       load;
   logic       free;
   bundle_type bundle;

   assign load         = in_valid_ff && free;
   assign req_ch.ready = !in_valid_ff || load;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready) begin
         in_kind_ff <= req_ch.kind;
         in_byte_ff <= req_ch.rx_byte;
      end
   end

   xmr_core #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (load),
      .kind      (in_kind_ff),
      .rx_byte   (in_byte_ff),
      .bundle    (bundle)
   );

   xmr_serial u_serial (
      .clock     (clock),
      .reset     (reset),
      .load      (load),
      .bundle_in (bundle),
      .free      (free),
      .rsp       (rsp_ch)
   );

endmodule

`default_nettype wire

[design/xmr_core.sv]
// Protocol state, configuration registers and per-request decision logic.
// Depends on xmr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xmr_core
   import xmr_pkg::*;
#(
   parameter int COUNT_WIDTH = 24
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_we,
   input  wire logic [1:0]           csr_index,
   input  wire logic [CAP_W-1:0]     csr_wdata,
   input  wire logic                 step,
   input  wire logic [1:0]           kind,
   input  wire logic [7:0]           rx_byte,
   output bundle_type                bundle
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_WAIT = 2'd1;
   localparam logic [1:0] PH_BODY = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   localparam int CMP_W = ((COUNT_WIDTH > CAP_W) ? COUNT_WIDTH : CAP_W) + 1;
   localparam int EXT_W = (COUNT_WIDTH > TOTAL_W) ? COUNT_WIDTH : TOTAL_W;

   logic                   use_crc_ff;
   logic [7:0]             retry_limit_ff;
   logic [15:0]            timeout_limit_ff;
   logic [CAP_W-1:0]       capacity_ff;

   logic [1:0]             phase_ff, phase_in;
   logic [7:0]             exp_id_ff, exp_id_in;
   logic [7:0]             req_byte_ff, req_byte_in;
   logic [15:0]            tcount_ff, tcount_in;
   logic [7:0]             retries_ff, retries_in;
   logic [INDEX_W-1:0]     idx_ff, idx_in;
   logic [15:0]            check_ff, check_in;
   logic [7:0]             first_chk_ff, first_chk_in;
   logic                   large_ff, large_in;
   logic                   bad_ff, bad_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;

   logic [INDEX_W-1:0]     size;
   logic [CMP_W-1:0]       need;
   logic                   overflow;
   logic                   sum_good;
   logic [EXT_W-1:0]       total_ext;

   logic       do_open, open_cm, open_dr;
   logic       do_abort, ab_cm, ab_dr;
   logic [2:0] ab_st;
   logic       do_bad;
   result_type head;
   logic [1:0] count;
   logic [2:0] end_status;

   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

   assign size     = large_ff ? INDEX_W'(LARGE_BLOCK) : INDEX_W'(SMALL_BLOCK);
   assign need     = CMP_W'(total_ff) + CMP_W'(size);
   assign overflow = CMP_W'(capacity_ff) < need;
   assign sum_good = use_crc_ff ? ({first_chk_ff, rx_byte} == check_ff)
                                : (rx_byte == check_ff[7:0]);

   always_comb begin
      phase_in     = phase_ff;
      exp_id_in    = exp_id_ff;
      req_byte_in  = req_byte_ff;
      tcount_in    = tcount_ff;
      retries_in   = retries_ff;
      idx_in       = idx_ff;
      check_in     = check_ff;
      first_chk_in = first_chk_ff;
      large_in     = large_ff;
      bad_in       = bad_ff;
      total_in     = total_ff;
      do_open      = 1'b0;
      open_cm      = 1'b0;
      open_dr      = 1'b0;
      do_abort     = 1'b0;
      ab_cm        = 1'b0;
      ab_dr        = 1'b0;
      ab_st        = ST_OK;
      do_bad       = 1'b0;
      head         = '0;
      count        = 2'd0;
      end_status   = ST_OK;

      if (step) begin
         case (kind)
            KIND_START: begin
               req_byte_in  = use_crc_ff ? CH_REQ : CH_NAK;
               exp_id_in    = 8'd1;
               retries_in   = retry_limit_ff;
               total_in     = '0;
               idx_in       = '0;
               check_in     = '0;
               first_chk_in = '0;
               large_in     = 1'b0;
               bad_in       = 1'b0;
               do_open      = 1'b1;
               open_dr      = (phase_ff == PH_BODY);
            end
            KIND_TICK: begin
               if (phase_ff == PH_WAIT) begin
                  if (tcount_ff < timeout_limit_ff) begin
                     head.send_valid = 1'b1;
                     head.send_byte  = req_byte_ff;
                     count           = 2'd1;
                     tcount_in       = tcount_ff + 16'd1;
                  end else begin
                     do_abort = 1'b1;
                     ab_st    = ST_NO_SYNC;
                  end
               end else if (phase_ff == PH_BODY) begin
                  do_bad = 1'b1;
               end
            end
            KIND_BYTE: begin
               if (phase_ff == PH_WAIT) begin
                  if (rx_byte == CH_SOH || rx_byte == CH_STX) begin
                     large_in     = (rx_byte == CH_STX);
                     idx_in       = '0;
                     check_in     = '0;
                     first_chk_in = '0;
                     bad_in       = 1'b0;
                     phase_in     = PH_BODY;
                  end else if (rx_byte == CH_EOT || rx_byte == CH_CAN) begin
                     head.send_valid = 1'b1;
                     head.send_byte  = CH_ACK;
                     head.done_res   = 1'b1;
                     head.status     = (rx_byte == CH_CAN) ? ST_CANCELLED : ST_OK;
                     count           = 2'd1;
                     phase_in        = PH_DONE;
                  end else begin
                     do_abort = 1'b1;
                     ab_st    = ST_BAD_HDR;
                  end
               end else if (phase_ff == PH_BODY) begin
                  idx_in = idx_ff + INDEX_W'(1);
                  if (idx_ff == INDEX_W'(0)) begin
                     if (rx_byte != exp_id_ff) begin
                        bad_in = 1'b1;
                     end
                  end else if (idx_ff == INDEX_W'(1)) begin
                     if (rx_byte != ~exp_id_ff) begin
                        bad_in = 1'b1;
                     end
                  end else if (idx_ff < size + INDEX_W'(2)) begin
                     check_in = use_crc_ff ? crc_step(check_ff, rx_byte)
                                           : {8'h00, check_ff[7:0] + rx_byte};
                     head.data_valid = 1'b1;
                     head.data_byte  = rx_byte;
                     count           = 2'd1;
                  end else if (use_crc_ff && idx_ff == size + INDEX_W'(2)) begin
                     first_chk_in = rx_byte;
                  end else if (bad_ff || !sum_good) begin
                     do_bad = 1'b1;
                  end else if (overflow) begin
                     do_abort = 1'b1;
                     ab_st    = ST_OVERFLOW;
                     ab_dr    = 1'b1;
                  end else begin
                     total_in    = total_ff + COUNT_WIDTH'(size);
                     exp_id_in   = exp_id_ff + 8'd1;
                     req_byte_in = CH_ACK;
                     do_open     = 1'b1;
                     open_cm     = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end

      // bad block: drop, then either spend a retry or give up
      if (do_bad) begin
         if (retries_ff == 8'd0) begin
            do_abort = 1'b1;
            ab_st    = ST_RETRIES;
            ab_dr    = 1'b1;
         end else begin
            retries_in  = retries_ff - 8'd1;
            req_byte_in = CH_NAK;
            do_open     = 1'b1;
            open_dr     = 1'b1;
         end
      end

      if (do_open) begin
         tcount_in = '0;
         if (timeout_limit_ff == 16'd0) begin
            do_abort = 1'b1;
            ab_st    = ST_NO_SYNC;
            ab_cm    = open_cm;
            ab_dr    = open_dr;
         end else begin
            head.send_valid = 1'b1;
            head.send_byte  = req_byte_in;
            head.commit     = open_cm;
            head.drop       = open_dr;
            count           = 2'd1;
            tcount_in       = 16'd1;
            phase_in        = PH_WAIT;
         end
      end

      if (do_abort) begin
         head            = '0;
         head.send_valid = 1'b1;
         head.send_byte  = CH_CAN;
         head.commit     = ab_cm;
         head.drop       = ab_dr;
         count           = 2'd3;
         end_status      = ab_st;
         phase_in        = PH_DONE;
      end
   end

   assign total_ext         = EXT_W'(total_in);
   assign bundle.count      = count;
   assign bundle.end_status = end_status;
   assign bundle.head       = head;
   assign bundle.total      = total_ext[TOTAL_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         use_crc_ff       <= 1'b1;
         retry_limit_ff   <= 8'd10;
         timeout_limit_ff <= 16'd16;
         capacity_ff      <= '1;
      end else if (csr_we) begin
         case (csr_index)
            REG_USE_CRC16:     use_crc_ff       <= csr_wdata[0];
            REG_RETRY_LIMIT:   retry_limit_ff   <= csr_wdata[7:0];
            REG_TIMEOUT_LIMIT: timeout_limit_ff <= csr_wdata[15:0];
            REG_BUF_CAPACITY:  capacity_ff      <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         exp_id_ff    <= 8'd1;
         req_byte_ff  <= 8'd0;
         tcount_ff    <= '0;
         retries_ff   <= '0;
         idx_ff       <= '0;
         check_ff     <= '0;
         first_chk_ff <= '0;
         large_ff     <= 1'b0;
         bad_ff       <= 1'b0;
         total_ff     <= '0;
      end else begin
         phase_ff     <= phase_in;
         exp_id_ff    <= exp_id_in;
         req_byte_ff  <= req_byte_in;
         tcount_ff    <= tcount_in;
         retries_ff   <= retries_in;
         idx_ff       <= idx_in;
         check_ff     <= check_in;
         first_chk_ff <= first_chk_in;
         large_ff     <= large_in;
         bad_ff       <= bad_in;
         total_ff     <= total_in;
      end
   end

endmodule

`default_nettype wire

[design/xmr_serial.sv]
// Result register: holds the results of one request and hands them out in order.
// Depends on xmr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module xmr_serial
   import xmr_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        load,
   input  wire bundle_type  bundle_in,
   output logic             free,
   xmr_rsp_if.source        rsp
);

   bundle_type bundle_ff;
   logic [1:0] count_ff;
   logic [1:0] pos_ff;
   logic       is_last;
   logic       pop;
   result_type cur;

   assign is_last = (pos_ff == count_ff - 2'd1);
   assign pop     = rsp.valid && rsp.ready;
   // free when empty or when the final result leaves this cycle
   assign free    = (count_ff == 2'd0) || (pop && is_last);

   always_comb begin
      cur = bundle_ff.head;
      if (pos_ff != 2'd0) begin
         cur            = '0;
         cur.send_valid = 1'b1;
         cur.send_byte  = CH_CAN;
         if (pos_ff == 2'd2) begin
            cur.done_res = 1'b1;
            cur.status   = bundle_ff.end_status;
         end
      end
   end

   assign rsp.valid          = (count_ff != 2'd0);
   assign rsp.send_valid     = cur.send_valid;
   assign rsp.send_byte      = cur.send_byte;
   assign rsp.data_valid     = cur.data_valid;
   assign rsp.data_byte      = cur.data_byte;
   assign rsp.commit         = cur.commit;
   assign rsp.drop           = cur.drop;
   assign rsp.done_res       = cur.done_res;
   assign rsp.status         = cur.status;
   assign rsp.received_total = bundle_ff.total;
   assign rsp.last           = is_last;

   always_ff @(posedge clock) begin
      if (load) begin
         bundle_ff <= bundle_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
         pos_ff   <= 2'd0;
      end else if (load) begin
         count_ff <= bundle_in.count;
         pos_ff   <= 2'd0;
      end else if (pop) begin
         if (is_last) begin
            count_ff <= 2'd0;
            pos_ff   <= 2'd0;
         end else begin
            pos_ff <= pos_ff + 2'd1;
         end
      end
   end

endmodule

`default_nettype wire

[verif/xmodem_receiver_tb.sv]
// Self-checking testbench for xmodem_receiver: drives link bytes, ticks and starts,
// predicts every response in a scoreboard class and compares it field by field.
// Depends on xmr_pkg, xmr_req_if, xmr_rsp_if and the xmodem_receiver RTL.
`timescale 1ns / 1ps

module xmodem_receiver_tb
   import xmr_pkg::*;
();

   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int         HOLD_CYCLES = 300;

   typedef enum logic [1:0] {XF_IDLE, XF_WAIT, XF_BODY, XF_DONE} xfer_phase_type;

   typedef enum int {
      BLK_GOOD, BLK_BAD_CHECK, BLK_BAD_ID, BLK_BAD_INV, BLK_REPEAT,
      BLK_CUT_TICK, BLK_CUT_START, BLK_RETUNE, BLK_NO_WAIT
   } block_shape_type;

   typedef struct packed {
      logic        send_valid;
      logic [7:0]  send_byte;
      logic        data_valid;
      logic [7:0]  data_byte;
      logic        commit;
      logic        drop;
      logic        done_res;
      logic [2:0]  status;
      logic [23:0] received_total;
      logic        last;
   } link_result_type;

   // Mirror of the receiver's registers and protocol state, plus the responses owed
   class xfer_scoreboard_type;
      bit              crc_mode;
      bit [7:0]        retry_lim;
      bit [15:0]       tick_lim;
      bit [23:0]       capacity;
      xfer_phase_type  phase;
      bit [7:0]        want_id;
      bit [7:0]        req_char;
      bit [15:0]       tick_count;
      bit [7:0]        retries_left;
      bit [10:0]       pos;
      bit [15:0]       check;
      bit [7:0]        check_hi;
      bit              big;
      bit              bad;
      bit [23:0]       total;
      int              errors;
      link_result_type owed_q[$];
      link_result_type burst[$];

      function new();
         crc_mode     = 1;
         retry_lim    = 10;
         tick_lim     = 16;
         capacity     = 24'hFFFFFF;
         phase        = XF_IDLE;
         want_id      = 8'd1;
         req_char     = 8'h00;
         tick_count   = 0;
         retries_left = 0;
         pos          = 0;
         check        = 0;
         check_hi     = 0;
         big          = 0;
         bad          = 0;
         total        = 0;
         errors       = 0;
      endfunction

      function void write_reg(logic [1:0] idx, logic [23:0] value);
         case (idx)
            REG_USE_CRC16:     crc_mode  = value[0];
            REG_RETRY_LIMIT:   retry_lim = value[7:0];
            REG_TIMEOUT_LIMIT: tick_lim  = value[15:0];
            REG_BUF_CAPACITY:  capacity  = value[23:0];
            default: ;
         endcase
      endfunction

      function void emit(bit snd, bit [7:0] snd_byte, bit dat, bit [7:0] dat_byte,
                         bit cm, bit dr, bit dn, bit [2:0] st);
         link_result_type r;
         if (burst.size() < 3) begin
            r.send_valid     = snd;
            r.send_byte      = snd_byte;
            r.data_valid     = dat;
            r.data_byte      = dat_byte;
            r.commit         = cm;
            r.drop           = dr;
            r.done_res       = dn;
            r.status         = st;
            r.received_total = total;
            r.last           = 0;
            burst.push_back(r);
         end
      endfunction

      function void cancel(bit [2:0] st, bit cm, bit dr);
         emit(1, CH_CAN, 0, 8'h00, cm, dr, 0, ST_OK);
         emit(1, CH_CAN, 0, 8'h00, 0, 0, 0, ST_OK);
         emit(1, CH_CAN, 0, 8'h00, 0, 0, 1, st);
         phase = XF_DONE;
      endfunction

      function void open_wait(bit cm, bit dr);
         tick_count = 0;
         if (tick_lim == 0) begin
            cancel(ST_NO_SYNC, cm, dr);
         end else begin
            emit(1, req_char, 0, 8'h00, cm, dr, 0, ST_OK);
            tick_count = 1;
            phase = XF_WAIT;
         end
      endfunction

      function void reject_block();
         if (retries_left == 0) begin
            cancel(ST_RETRIES, 0, 1);
         end else begin
            retries_left = retries_left - 8'd1;
            req_char = CH_NAK;
            open_wait(0, 1);
         end
      endfunction

      function bit [15:0] crc_update(bit [15:0] c, bit [7:0] b);
         bit [15:0] v;
         v = c ^ {b, 8'h00};
         for (int i = 0; i < 8; i++)
            v = v[15] ? ((v << 1) ^ CRC_POLY) : (v << 1);
         return v;
      endfunction

      function void body_byte(bit [7:0] b);
         int unsigned blk_len;
         bit [10:0]   idx;
         bit          ok;
         blk_len = big ? LARGE_BLOCK : SMALL_BLOCK;
         idx = pos;
         pos = pos + 11'd1;
         if (idx == 0) begin
            if (b != want_id) bad = 1;
         end else if (idx == 1) begin
            if (b != 8'hFF - want_id) bad = 1;
         end else if (idx < blk_len + 2) begin
            // the check kind follows the register byte by byte
            check = crc_mode ? crc_update(check, b) : {8'h00, check[7:0] + b};
            emit(0, 8'h00, 1, b, 0, 0, 0, ST_OK);
         end else if (crc_mode && idx == blk_len + 2) begin
            check_hi = b;
         end else begin
            ok = crc_mode ? ({check_hi, b} == check) : (b == check[7:0]);
            if (bad || !ok)
               reject_block();
            else if (capacity <= total || capacity - total < blk_len)
               cancel(ST_OVERFLOW, 0, 1);
            else begin
               total = total + blk_len[23:0];
               want_id = want_id + 8'd1;
               req_char = CH_ACK;
               open_wait(1, 0);
            end
         end
      endfunction

      function void header_byte(bit [7:0] b);
         if (b == CH_SOH || b == CH_STX) begin
            big      = (b == CH_STX);
            pos      = 0;
            check    = 0;
            check_hi = 0;
            bad      = 0;
            phase    = XF_BODY;
         end else if (b == CH_EOT) begin
            emit(1, CH_ACK, 0, 8'h00, 0, 0, 1, ST_OK);
            phase = XF_DONE;
         end else if (b == CH_CAN) begin
            emit(1, CH_ACK, 0, 8'h00, 0, 0, 1, ST_CANCELLED);
            phase = XF_DONE;
         end else begin
            cancel(ST_BAD_HDR, 0, 0);
         end
      endfunction

      function void note_request(logic [1:0] kind, logic [7:0] b);
         link_result_type r;
         bit              was_body;
         burst.delete();
         case (kind)
            KIND_START: begin
               was_body     = (phase == XF_BODY);
               req_char     = crc_mode ? CH_REQ : CH_NAK;
               want_id      = 8'd1;
               retries_left = retry_lim;
               total        = 0;
               pos          = 0;
               check        = 0;
               check_hi     = 0;
               big          = 0;
               bad          = 0;
               open_wait(0, was_body);
            end
            KIND_TICK: begin
               if (phase == XF_WAIT) begin
                  if (tick_count < tick_lim) begin
                     emit(1, req_char, 0, 8'h00, 0, 0, 0, ST_OK);
                     tick_count = tick_count + 16'd1;
                  end else begin
                     cancel(ST_NO_SYNC, 0, 0);
                  end
               end else if (phase == XF_BODY) begin
                  reject_block();
               end
            end
            KIND_BYTE: begin
               if (phase == XF_WAIT)
                  header_byte(b);
               else if (phase == XF_BODY)
                  body_byte(b);
            end
            default: ;
         endcase
         if (burst.size() != 0) begin
            r = burst.pop_back();
            r.last = 1;
            burst.push_back(r);
         end
         foreach (burst[i])
            owed_q.push_back(burst[i]);
      endfunction

      function void compare_field(string name, logic [31:0] want, logic [31:0] actual);
         if (want !== actual) begin
            if (errors < 40)
               $error("%s: expected 0x%0h, got 0x%0h", name, want, actual);
            errors++;
         end
      endfunction

      function void check_result(link_result_type got);
         link_result_type want;
         if (owed_q.size() == 0) begin
            $error("response with no request outstanding");
            errors++;
         end else begin
            want = owed_q.pop_front();
            compare_field("send_valid", 32'(want.send_valid), 32'(got.send_valid));
            compare_field("send_byte", 32'(want.send_byte), 32'(got.send_byte));
            compare_field("data_valid", 32'(want.data_valid), 32'(got.data_valid));
            compare_field("data_byte", 32'(want.data_byte), 32'(got.data_byte));
            compare_field("commit", 32'(want.commit), 32'(got.commit));
            compare_field("drop", 32'(want.drop), 32'(got.drop));
            compare_field("done_res", 32'(want.done_res), 32'(got.done_res));
            compare_field("status", 32'(want.status), 32'(got.status));
            compare_field("received_total", 32'(want.received_total),
                          32'(got.received_total));
            compare_field("last", 32'(want.last), 32'(got.last));
         end
      endfunction

      function int pending();
         return owed_q.size();
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [1:0]  csr_index;
   logic [23:0] csr_wdata;

   xmr_req_if req_bus ();
   xmr_rsp_if rsp_bus ();

   xfer_scoreboard_type sb = new();

   bit          send_gaps = 1;
   bit          recv_gaps = 1;
   bit          hold_rsp = 0;
   bit          force_large = 0;
   int          large_left = 2;
   int          items_sent = 0;
   logic [15:0] phase_timeout = 16'd16;

   xmodem_receiver u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial clock = 0;
   always #5 clock = ~clock;

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // Offer one request from a falling edge and hold it until accepted
   task automatic push_request(input logic [1:0] kind, input logic [7:0] value,
                               input bit counted);
      int gap;
      gap = send_gaps ? $urandom_range(0, 6) : 0;
      if (gap != 0) begin
         req_bus.valid = 0;
         repeat (gap) @(negedge clock);
      end
      req_bus.kind    = kind;
      req_bus.rx_byte = value;
      req_bus.valid   = 1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sb.note_request(kind, value);
      if (counted) items_sent++;
      @(negedge clock);
   endtask

   // Stop sending and let every owed response drain
   task automatic settle();
      req_bus.valid = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [23:0] value);
      csr_we    = 1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 0;
      sb.write_reg(idx, value);
   endtask

   task automatic send_block(input bit large_blk, input block_shape_type shape,
                             input int max_cut);
      int          blk_len;
      int          n;
      logic [7:0]  id;
      logic [7:0]  value;
      logic [15:0] trailer;
      blk_len = large_blk ? LARGE_BLOCK : SMALL_BLOCK;
      id = (shape == BLK_REPEAT) ? sb.want_id - 8'd1 : sb.want_id;
      n = (shape == BLK_CUT_TICK || shape == BLK_CUT_START) ?
          $urandom_range(0, max_cut) : blk_len + 2;
      push_request(KIND_BYTE, large_blk ? CH_STX : CH_SOH, 1);
      for (int i = 0; i < n; i++) begin
         if (shape == BLK_RETUNE && i == blk_len / 2 + 2) begin
            settle();
            write_reg(REG_USE_CRC16, {23'd0, !sb.crc_mode});
         end
         if (i == 0)
            value = (shape == BLK_BAD_ID) ? id ^ (8'd1 << $urandom_range(0, 7)) : id;
         else if (i == 1)
            value = (shape == BLK_BAD_INV) ? ~id ^ (8'd1 << $urandom_range(0, 7)) : ~id;
         else
            value = 8'($urandom_range(0, 255));
         push_request(KIND_BYTE, value, 1);
      end
      if (shape == BLK_CUT_TICK) begin
         push_request(KIND_TICK, 8'($urandom_range(0, 255)), 1);
      end else if (shape == BLK_CUT_START) begin
         push_request(KIND_START, 8'($urandom_range(0, 255)), 1);
      end else begin
         // with no request budget the commit has to ride on the first CAN
         if (shape == BLK_NO_WAIT) begin
            settle();
            write_reg(REG_TIMEOUT_LIMIT, 24'd0);
         end
         trailer = sb.crc_mode ? sb.check : {8'h00, sb.check[7:0]};
         if (shape == BLK_BAD_CHECK)
            trailer = trailer ^ (16'h0001 << $urandom_range(0, sb.crc_mode ? 15 : 7));
         if (sb.crc_mode)
            push_request(KIND_BYTE, trailer[15:8], 1);
         push_request(KIND_BYTE, trailer[7:0], 1);
         if (shape == BLK_NO_WAIT) begin
            settle();
            write_reg(REG_TIMEOUT_LIMIT, {8'd0, phase_timeout});
         end
      end
   endtask

   // room: counted requests this sequence may still send
   task automatic random_sequence(input int room);
      int              pick;
      int              blk_len;
      int              cut_max;
      bit              large_blk;
      block_shape_type shape;
      logic [7:0]      junk;
      send_gaps = ($urandom_range(0, 3) != 0);
      recv_gaps = ($urandom_range(0, 3) != 0);
      if (sb.phase == XF_BODY) begin
         push_request(KIND_TICK, 8'h00, 1);
      end else if (sb.phase != XF_WAIT) begin
         if ($urandom_range(0, 4) == 0) begin
            pick = $urandom_range(0, 2);
            push_request(pick == 0 ? KIND_BYTE : (pick == 1 ? KIND_TICK : KIND_UNUSED),
                         8'($urandom_range(0, 255)), 0);
         end
         push_request(KIND_START, 8'($urandom_range(0, 255)), 1);
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 76) begin
            if (pick < 45)      shape = BLK_GOOD;
            else if (pick < 50) shape = BLK_BAD_CHECK;
            else if (pick < 54) shape = BLK_BAD_ID;
            else if (pick < 57) shape = BLK_BAD_INV;
            else if (pick < 61) shape = BLK_REPEAT;
            else if (pick < 67) shape = BLK_CUT_TICK;
            else if (pick < 71) shape = BLK_CUT_START;
            else if (pick < 74) shape = BLK_RETUNE;
            else                shape = BLK_NO_WAIT;
            large_blk = force_large || (large_left > 0 && $urandom_range(0, 9) == 0);
            if (large_blk) begin
               if (!force_large) large_left--;
               force_large = 0;
            end
            blk_len = large_blk ? LARGE_BLOCK : SMALL_BLOCK;
            // a whole block that does not fit the budget is cut short instead
            if (shape != BLK_CUT_TICK && shape != BLK_CUT_START && room < blk_len + 5)
               shape = ($urandom_range(0, 1) == 0) ? BLK_CUT_TICK : BLK_CUT_START;
            cut_max = room - 2;
            if (cut_max > blk_len + 1) cut_max = blk_len + 1;
            if (cut_max < 0) cut_max = 0;
            send_block(large_blk, shape, cut_max);
         end else if (pick < 86) begin
            push_request(KIND_TICK, 8'($urandom_range(0, 255)), 1);
         end else if (pick < 89) begin
            push_request(KIND_BYTE, CH_EOT, 1);
         end else if (pick < 92) begin
            push_request(KIND_BYTE, CH_CAN, 1);
         end else if (pick < 96) begin
            do
               junk = 8'($urandom_range(0, 255));
            while (junk == CH_SOH || junk == CH_STX || junk == CH_EOT || junk == CH_CAN);
            push_request(KIND_BYTE, junk, 1);
         end else if (pick < 98) begin
            push_request(KIND_START, 8'($urandom_range(0, 255)), 1);
         end else begin
            push_request(KIND_UNUSED, 8'($urandom_range(0, 255)), 0);
         end
      end
   endtask

   // Response side: random stalls, one long hold-off on request
   initial begin
      int              stall;
      link_result_type got;
      rsp_bus.ready = 0;
      while (reset !== 1'b0) @(negedge clock);
      forever begin
         if (hold_rsp) begin
            stall = HOLD_CYCLES;
            hold_rsp = 0;
         end else begin
            stall = recv_gaps ? $urandom_range(0, 6) : 0;
         end
         if (stall != 0) begin
            rsp_bus.ready = 0;
            repeat (stall) @(negedge clock);
         end
         rsp_bus.ready = 1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         got.send_valid     = rsp_bus.send_valid;
         got.send_byte      = rsp_bus.send_byte;
         got.data_valid     = rsp_bus.data_valid;
         got.data_byte      = rsp_bus.data_byte;
         got.commit         = rsp_bus.commit;
         got.drop           = rsp_bus.drop;
         got.done_res       = rsp_bus.done_res;
         got.status         = rsp_bus.status;
         got.received_total = rsp_bus.received_total;
         got.last           = rsp_bus.last;
         sb.check_result(got);
         @(negedge clock);
      end
   end

   initial begin
      logic        crc;
      logic [7:0]  retry;
      logic [23:0] cap;
      int          mark;
      int          quota;
      reset           = 1;
      csr_we          = 0;
      csr_index       = REG_USE_CRC16;
      csr_wdata       = 24'd0;
      req_bus.valid   = 0;
      req_bus.kind    = KIND_BYTE;
      req_bus.rx_byte = 8'h00;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // idle: everything but a start is dropped
      push_request(KIND_BYTE, 8'h00, 1);
      push_request(KIND_TICK, 8'h00, 1);
      push_request(KIND_UNUSED, 8'hFF, 1);
      // clean end, then cancel, then a bad header
      push_request(KIND_START, 8'h00, 1);
      push_request(KIND_TICK, 8'h00, 1);
      push_request(KIND_BYTE, CH_EOT, 1);
      push_request(KIND_TICK, 8'h00, 1);
      push_request(KIND_START, 8'hFF, 1);
      push_request(KIND_BYTE, CH_CAN, 1);
      push_request(KIND_START, 8'h00, 1);
      push_request(KIND_BYTE, 8'hFF, 1);
      // restart mid-block, then a block killed by a tick
      push_request(KIND_START, 8'h00, 1);
      push_request(KIND_BYTE, CH_SOH, 1);
      push_request(KIND_BYTE, 8'h01, 1);
      push_request(KIND_START, 8'h00, 1);
      push_request(KIND_BYTE, CH_STX, 1);
      push_request(KIND_TICK, 8'h00, 1);
      // request budget runs out
      settle();
      write_reg(REG_TIMEOUT_LIMIT, 24'd2);
      push_request(KIND_START, 8'h00, 1);
      push_request(KIND_TICK, 8'h00, 1);
      push_request(KIND_TICK, 8'h00, 1);
      settle();
      write_reg(REG_TIMEOUT_LIMIT, 24'd0);
      push_request(KIND_START, 8'h00, 1);
      // no retries left: the first bad block aborts
      settle();
      write_reg(REG_TIMEOUT_LIMIT, 24'hFFFF);
      write_reg(REG_RETRY_LIMIT, 24'd0);
      push_request(KIND_START, 8'h00, 1);
      push_request(KIND_BYTE, CH_SOH, 1);
      push_request(KIND_TICK, 8'h00, 1);

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin
               crc = 1; retry = 8'd10; phase_timeout = 16'd16; cap = 24'hFFFFFF;
               quota = 135;
            end
            1: begin
               crc = 0; retry = 8'd255; phase_timeout = 16'hFFFF; cap = 24'hFFFFFF;
               quota = 135;
            end
            2: begin
               crc = 1; retry = 8'd0; phase_timeout = 16'd1; cap = 24'd0;
               quota = 135;
            end
            default: begin
               crc = 1'($urandom_range(0, 1));
               retry = 8'($urandom_range(0, 5));
               phase_timeout = 16'($urandom_range(1, 6));
               cap = 24'($urandom_range(0, 1500));
               quota = 40;
            end
         endcase
         settle();
         write_reg(REG_USE_CRC16, {23'd0, crc});
         write_reg(REG_RETRY_LIMIT, {16'd0, retry});
         write_reg(REG_TIMEOUT_LIMIT, {8'd0, phase_timeout});
         write_reg(REG_BUF_CAPACITY, cap);
         if (p == 0) hold_rsp = 1;
         if (p == 3) force_large = 1;
         mark = items_sent;
         while (items_sent - mark < quota) random_sequence(quota - (items_sent - mark));
      end

      req_bus.valid = 0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
